FILE: hdl/bass_pkg.sv
// Shared types, character codes and defaults for the bracket-aware separator scanner.
package bass_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam logic [7:0]  SEP_RESET       = 8'd44;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LSQ    = 8'h5B;
  localparam logic [7:0] CH_RSQ    = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  typedef enum logic [1:0] {
    CL_PAREN  = 2'd0,
    CL_SQUARE = 2'd1,
    CL_BRACE  = 2'd2,
    CL_QUOTE  = 2'd3
  } closer_t;

  typedef struct packed {
    logic    is_open;
    closer_t open_code;
    logic    is_close;
    closer_t close_code;
    logic    is_sep;
  } chcls_t;

  typedef struct packed {
    logic       is_split;
    logic       closes_outer;
    logic [4:0] depth;
    logic       overflow;
  } res_t;

endpackage

FILE: hdl/bass_classify.sv
// Character classifier: opening and closing bracket codes and separator match.
module bass_classify import bass_pkg::*; (
  input  logic [7:0] ch,
  input  logic [7:0] sep,
  output chcls_t     cls
);

  always_comb begin
    cls.is_open    = 1'b1;
    cls.open_code  = CL_PAREN;
    case (ch)
      CH_LPAREN: cls.open_code = CL_PAREN;
      CH_LSQ:    cls.open_code = CL_SQUARE;
      CH_LBRACE: cls.open_code = CL_BRACE;
      CH_QUOTE:  cls.open_code = CL_QUOTE;
      default:   cls.is_open   = 1'b0;
    endcase

    cls.is_close   = 1'b1;
    cls.close_code = CL_PAREN;
    case (ch)
      CH_RPAREN: cls.close_code = CL_PAREN;
      CH_RSQ:    cls.close_code = CL_SQUARE;
      CH_RBRACE: cls.close_code = CL_BRACE;
      CH_QUOTE:  cls.close_code = CL_QUOTE;
      default:   cls.is_close   = 1'b0;
    endcase

    cls.is_sep = (ch == sep);
  end

endmodule

FILE: hdl/bass_stack.sv
// Closer stack held as a shift line (top at entry 0), count, overflow and per-character step.
module bass_stack import bass_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic          start,
  input  chcls_t        cls,
  output res_t          res,
  output logic [CW-1:0] cnt
);

  closer_t       stack_r [STACK_DEPTH];
  logic [CW-1:0] cnt_r, cnt_nxt, cnt_eff;
  logic          ovf_r, ovf_nxt, ovf_eff;
  logic          pop, push, full;
  logic [CW+4:0] cnt_wide;

  always_comb begin
    cnt_eff = start ? '0 : cnt_r;
    ovf_eff = start ? 1'b0 : ovf_r;
    full    = (cnt_eff == CW'(STACK_DEPTH));
    // top-of-stack match is checked first so a closing quote pops
    pop     = (cnt_eff != '0) && cls.is_close && (cls.close_code == stack_r[0]);
    push    = !pop && cls.is_open;
    cnt_nxt = cnt_eff;
    if (pop) begin
      cnt_nxt = cnt_eff - CW'(1);
    end else if (push && !full) begin
      cnt_nxt = cnt_eff + CW'(1);
    end
    ovf_nxt  = ovf_eff | (push && full);
    cnt_wide = {5'd0, cnt_nxt};

    res.is_split     = !pop && !cls.is_open && (cnt_eff == '0) && cls.is_sep;
    res.closes_outer = pop && (cnt_eff == CW'(1));
    res.depth        = cnt_wide[4:0];
    res.overflow     = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (step_en) begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // push shifts entries down, pop shifts them up
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_ent
    always_ff @(posedge clk) begin
      if (step_en) begin
        if (push && !full) begin
          if (i == 0) begin
            stack_r[i] <= cls.open_code;
          end else begin
            stack_r[i] <= stack_r[(i == 0) ? 0 : i - 1];
          end
        end else if (pop && (i + 1 < STACK_DEPTH)) begin
          stack_r[i] <= stack_r[(i + 1 < STACK_DEPTH) ? i + 1 : i];
        end
      end
    end
  end

  assign cnt = cnt_r;

endmodule

FILE: hdl/bracket_aware_separator_scanner.sv
// Top level: input register, classify and stack step, result register, separator register.
//
// Scans a byte stream one character per transfer and reports, per character,
// whether it is a separator outside all brackets, whether it closed the
// outermost bracket, the nesting depth after it and a sticky overflow flag.
// Input channel: in_valid/in_stall with in_ch and in_start_req; in_start_req
// empties the stack and clears overflow before its character is handled.
// Result channel: out_valid/out_stall with out_is_split, out_closes_outer,
// out_depth and out_overflow, one result per input character, in order.
// Throughput: one character per cycle while out_stall is low; the stack top
// sits at a fixed entry of a shift-line stack, so compare, push and pop all
// work from that entry.
// A stalled result holds in the result register while the input register keeps
// one more character; in_stall rises only when both are full.
// Reset (rst_n low, synchronous) empties both registers and the stack, clears
// overflow and sets the separator to a comma. cfg_wr_en writes the separator;
// write it only while no character is in flight.
module bracket_aware_separator_scanner import bass_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_start_req,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_is_split,
  output logic       out_closes_outer,
  output logic [4:0] out_depth,
  output logic       out_overflow,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic          in_valid_r;
  logic [7:0]    ch_r;
  logic          start_r;
  logic          out_valid_r;
  res_t          res_r;
  logic [7:0]    sep_r;
  logic          adv, in_take;
  chcls_t        cls;
  res_t          res;
  logic [CW-1:0] cnt;

  assign adv     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= SEP_RESET;
    end else if (cfg_wr_en) begin
      sep_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ch_r    <= in_ch;
      start_r <= in_start_req;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  bass_classify u_classify (
    .ch  (ch_r),
    .sep (sep_r),
    .cls (cls)
  );

  bass_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .start   (start_r),
    .cls     (cls),
    .res     (res),
    .cnt     (cnt)
  );

  assign out_valid        = out_valid_r;
  assign out_is_split     = res_r.is_split;
  assign out_closes_outer = res_r.closes_outer;
  assign out_depth        = res_r.depth;
  assign out_overflow     = res_r.overflow;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_split_xor_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.is_split && res_r.closes_outer))
    else $error("split and outer close on one character");

  a_split_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.is_split || res_r.closes_outer)) |-> (res_r.depth == 5'd0))
    else $error("split or outer close at nonzero depth");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_valid_r)
    else $error("input register lost a stalled character");

endmodule
